// File: rtl/epoch_seconds_to_calendar_assert.svh
// assertion helpers shared by the calendar converter
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/esc_pkg.sv
package esc_pkg;

   // calendar constants
   localparam int EPOCH_YEAR      = 1970;
   localparam int SECS_PER_MIN    = 60;
   localparam int SECS_PER_HOUR   = 3600;
   localparam int SECS_PER_DAY    = 86400;
   localparam int MAX_START_HOUR  = 23;
   localparam int START_HOUR_RST  = 8;
   localparam int LAST_MONTH      = 11;

   // field widths
   localparam int SECS_W  = 31;
   localparam int TOTAL_W = 32;
   localparam int DAYS_W  = 15;
   localparam int YEAR_W  = 12;
   localparam int PC_W    = 3;
   localparam int CNT_W   = 4;

   // reciprocal multiplier widths
   localparam int QX_W    = 25;
   localparam int RECIP_W = 26;
   localparam int QPROD_W = QX_W + RECIP_W;

   // year residues at the epoch, worked out at elaboration
   localparam logic [YEAR_W-1:0] EPOCH_YEAR_V = YEAR_W'(EPOCH_YEAR);
   localparam logic [6:0]        EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0]        EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

   // microcode step addresses
   localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
   localparam logic [PC_W-1:0] PC_DAYS   = 3'd1;
   localparam logic [PC_W-1:0] PC_HOURS  = 3'd2;
   localparam logic [PC_W-1:0] PC_MINS   = 3'd3;
   localparam logic [PC_W-1:0] PC_YEARS  = 3'd4;
   localparam logic [PC_W-1:0] PC_MONTHS = 3'd5;
   localparam logic [PC_W-1:0] PC_SEND   = 3'd6;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_DIV,
      OP_YEAR,
      OP_MONTH,
      OP_SEND
   } op_type;

   typedef enum logic [1:0] {
      DSEL_DAY,
      DSEL_HOUR,
      DSEL_MIN
   } dsel_type;

   typedef struct packed {
      op_type            op;
      dsel_type          dsel;
      logic [CNT_W-1:0]  iters;
      logic [PC_W-1:0]   next_pc;
   } ucode_type;

   typedef struct packed {
      logic [2:0]          pre;
      logic [RECIP_W-1:0]  mul;
      logic [5:0]          post;
   } recip_type;

   // control store: one word per step, a step repeats until its exit condition holds
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_WAIT:   w = '{op: OP_WAIT,  dsel: DSEL_DAY,  iters: 4'd0,  next_pc: PC_DAYS};
         PC_DAYS:   w = '{op: OP_DIV,   dsel: DSEL_DAY,  iters: 4'd1,  next_pc: PC_HOURS};
         PC_HOURS:  w = '{op: OP_DIV,   dsel: DSEL_HOUR, iters: 4'd1,  next_pc: PC_MINS};
         PC_MINS:   w = '{op: OP_DIV,   dsel: DSEL_MIN,  iters: 4'd1,  next_pc: PC_YEARS};
         PC_YEARS:  w = '{op: OP_YEAR,  dsel: DSEL_DAY,  iters: 4'd0,  next_pc: PC_MONTHS};
         PC_MONTHS: w = '{op: OP_MONTH, dsel: DSEL_DAY,  iters: 4'd0,  next_pc: PC_SEND};
         PC_SEND:   w = '{op: OP_SEND,  dsel: DSEL_DAY,  iters: 4'd0,  next_pc: PC_WAIT};
         default:   w = '{op: OP_WAIT,  dsel: DSEL_DAY,  iters: 4'd0,  next_pc: PC_WAIT};
      endcase
      return w;
   endfunction

   // divisor constant of each division step
   function automatic logic [TOTAL_W-1:0] divisor_of(input dsel_type dsel);
      logic [TOTAL_W-1:0] d;
      case (dsel)
         DSEL_DAY:  d = TOTAL_W'(SECS_PER_DAY);
         DSEL_HOUR: d = TOTAL_W'(SECS_PER_HOUR);
         DSEL_MIN:  d = TOTAL_W'(SECS_PER_MIN);
         default:   d = TOTAL_W'(SECS_PER_DAY);
      endcase
      return d;
   endfunction

   // reciprocal of each divisor: shift out its power of two, then multiply and shift,
   // exact over the dividends each step can see
   function automatic recip_type recip_of(input dsel_type dsel);
      recip_type r;
      case (dsel)
         DSEL_DAY:  r = '{pre: 3'd7, mul: RECIP_W'(50903317), post: 6'd35};
         DSEL_HOUR: r = '{pre: 3'd4, mul: RECIP_W'(9321),     post: 6'd21};
         DSEL_MIN:  r = '{pre: 3'd2, mul: RECIP_W'(1093),     post: 6'd14};
         default:   r = '{pre: 3'd7, mul: RECIP_W'(50903317), post: 6'd35};
      endcase
      return r;
   endfunction

   // month length, month counted from 0
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] n;
      case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   n = 5'd30;
         4'd1:                                      n = leap ? 5'd29 : 5'd28;
         default:                                   n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar.sv
// Epoch seconds to calendar date and time.
// Input channel req_: one transaction carries req_epoch_seconds (31 bits, seconds
// since 1970-01-01 00:00:00). Result channel rsp_: one transaction per input
// carrying year, month, day, hour, minute and second. Both use valid/ready.
// csr_wr_en/csr_wr_data write the start hour (time zone offset, 0..23, larger
// values act as 23); write it only while the block is idle.
// Control is a small microprogram: a step counter walks a constant control store.
// Steps in order: the wait step takes a transaction and loads the seconds plus the
// start hour; divisions by 86400, 3600 and 60 follow (reciprocal multiply for the
// quotient, multiply back and subtract for the remainder); a year loop subtracts
// one year per pass and a month loop one month per pass, each with an exit pass;
// a send step then loads the result. The step counter goes back to the wait step,
// so the next transaction can be taken in the cycle after the result is loaded.
// The result sits in an output register: a stalled receiver does not stop the
// next transaction from being accepted and converted; only loading a new result
// waits for the old one to be taken.
// Reset (synchronous, active high) drops any transaction in flight, clears
// rsp_valid and sets the start hour back to 8.
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [esc_pkg::SECS_W-1:0]    req_epoch_seconds,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [10:0]                   rsp_year_out,
   output logic [3:0]                    rsp_month_out,
   output logic [4:0]                    rsp_day_out,
   output logic [4:0]                    rsp_hour_out,
   output logic [5:0]                    rsp_minute_out,
   output logic [5:0]                    rsp_second_out,
   input  logic                          csr_wr_en,
   input  logic [4:0]                    csr_wr_data
);

   // sequencer and datapath registers
   logic [esc_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [esc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [esc_pkg::TOTAL_W-1:0] rem_ff, rem_in;
   logic [esc_pkg::DAYS_W-1:0]  quo_ff, quo_in;
   logic [esc_pkg::DAYS_W-1:0]  days_ff, days_in;
   logic [esc_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [6:0]                  ymod100_ff, ymod100_in;
   logic [8:0]                  ymod400_ff, ymod400_in;
   logic [3:0]                  month_ff, month_in;
   logic [4:0]                  hour_ff, hour_in;
   logic [5:0]                  minute_ff, minute_in;
   logic [5:0]                  second_ff, second_in;
   logic [4:0]                  start_hour_ff, start_hour_in;

   // output registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_year_ff, rsp_year_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;

   // combinational datapath
   esc_pkg::ucode_type          word;
   esc_pkg::ucode_type          next_word;
   esc_pkg::recip_type          recip;
   logic                        done;
   logic [4:0]                  hr0;
   logic [16:0]                 hr_secs;
   logic [esc_pkg::TOTAL_W-1:0] total;
   logic [esc_pkg::TOTAL_W-1:0] divisor;
   logic [esc_pkg::QX_W-1:0]    qx;
   logic [esc_pkg::QPROD_W-1:0] qprod;
   logic [esc_pkg::DAYS_W-1:0]  q_est;
   logic [esc_pkg::TOTAL_W-1:0] rem_back;
   logic                        leap;
   logic [8:0]                  ylen;
   logic [4:0]                  mlen;

   assign word      = esc_pkg::ucode_rom(pc_ff);
   assign next_word = esc_pkg::ucode_rom(word.next_pc);

   // start hour saturated at 23, turned into seconds
   assign hr0     = (start_hour_ff > 5'(esc_pkg::MAX_START_HOUR)) ?
                    5'(esc_pkg::MAX_START_HOUR) : start_hour_ff;
   assign hr_secs = 17'(hr0 * esc_pkg::SECS_PER_HOUR);
   assign total   = {1'b0, req_epoch_seconds} + esc_pkg::TOTAL_W'(hr_secs);

   // quotient by reciprocal multiplication, remainder by multiplying back
   assign divisor  = esc_pkg::divisor_of(word.dsel);
   assign recip    = esc_pkg::recip_of(word.dsel);
   assign qx       = esc_pkg::QX_W'(rem_ff >> recip.pre);
   assign qprod    = esc_pkg::QPROD_W'(qx) * esc_pkg::QPROD_W'(recip.mul);
   assign q_est    = esc_pkg::DAYS_W'(qprod >> recip.post);
   assign rem_back = rem_ff - (esc_pkg::TOTAL_W'(quo_ff) * divisor);

   // gregorian leap rule from the tracked residues
   assign leap = ((year_ff[1:0] == 2'd0) && (ymod100_ff != 7'd0)) || (ymod400_ff == 9'd0);
   assign ylen = leap ? 9'd366 : 9'd365;
   assign mlen = esc_pkg::month_len(month_ff, leap);

   // microcode execution
   always_comb begin
      pc_in         = pc_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      days_in       = days_ff;
      year_in       = year_ff;
      ymod100_in    = ymod100_ff;
      ymod400_in    = ymod400_ff;
      month_in      = month_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      start_hour_in = csr_wr_en ? csr_wr_data : start_hour_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;
      req_ready     = 1'b0;
      done          = 1'b0;

      case (word.op)
         esc_pkg::OP_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rem_in     = total;
               quo_in     = '0;
               year_in    = esc_pkg::EPOCH_YEAR_V;
               ymod100_in = esc_pkg::EPOCH_MOD100;
               ymod400_in = esc_pkg::EPOCH_MOD400;
               month_in   = 4'd0;
               done       = 1'b1;
            end
         end
         esc_pkg::OP_DIV: begin
            if (cnt_ff != '0) begin
               quo_in = q_est;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               rem_in = rem_back;
               done   = 1'b1;
               case (word.dsel)
                  esc_pkg::DSEL_DAY:  days_in   = quo_ff;
                  esc_pkg::DSEL_HOUR: hour_in   = quo_ff[4:0];
                  esc_pkg::DSEL_MIN: begin
                     minute_in = quo_ff[5:0];
                     second_in = rem_back[5:0];
                  end
                  default:            days_in   = quo_ff;
               endcase
            end
         end
         esc_pkg::OP_YEAR: begin
            if (days_ff < esc_pkg::DAYS_W'(ylen)) begin
               done = 1'b1;
            end else begin
               days_in    = days_ff - esc_pkg::DAYS_W'(ylen);
               year_in    = year_ff + 1'b1;
               ymod100_in = (ymod100_ff == 7'd99)  ? 7'd0 : ymod100_ff + 1'b1;
               ymod400_in = (ymod400_ff == 9'd399) ? 9'd0 : ymod400_ff + 1'b1;
            end
         end
         esc_pkg::OP_MONTH: begin
            if ((month_ff == 4'(esc_pkg::LAST_MONTH)) ||
                (days_ff < esc_pkg::DAYS_W'(mlen))) begin
               done = 1'b1;
            end else begin
               days_in  = days_ff - esc_pkg::DAYS_W'(mlen);
               month_in = month_ff + 1'b1;
            end
         end
         esc_pkg::OP_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = year_ff[10:0];
               rsp_month_in  = month_ff + 1'b1;
               rsp_day_in    = 5'(days_ff + 1'b1);
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
               rsp_second_in = second_ff;
               done          = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase

      // jump on exit, preloading the iteration count of the target step
      if (done) begin
         pc_in  = word.next_pc;
         cnt_in = next_word.iters;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= esc_pkg::PC_WAIT;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         start_hour_ff <= 5'(esc_pkg::START_HOUR_RST);
      end else begin
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         start_hour_ff <= start_hour_in;
      end
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      days_ff       <= days_in;
      year_ff       <= year_in;
      ymod100_ff    <= ymod100_in;
      ymod400_ff    <= ymod400_in;
      month_ff      <= month_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   // result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_year_out   = rsp_year_ff;
   assign rsp_month_out  = rsp_month_ff;
   assign rsp_day_out    = rsp_day_ff;
   assign rsp_hour_out   = rsp_hour_ff;
   assign rsp_minute_out = rsp_minute_ff;
   assign rsp_second_out = rsp_second_ff;

   // checks
   `ESC_ASSERT_NEXT(a_accept_starts_days, (req_valid && req_ready),
      (pc_ff == esc_pkg::PC_DAYS), "accepted transaction did not start day division")
   `ESC_ASSERT_NOW(a_div_rem_bound, (word.op == esc_pkg::OP_DIV && cnt_ff == '0),
      (rem_back < divisor), "division remainder out of range")
   `ESC_ASSERT_NEXT(a_year_step, (word.op == esc_pkg::OP_YEAR && !done),
      (year_ff == $past(year_ff) + 1'b1), "year loop did not advance the year")
   `ESC_ASSERT_NEXT(a_result_sane, (word.op == esc_pkg::OP_SEND && done),
      (rsp_valid && rsp_month_out >= 4'd1 && rsp_month_out <= 4'd12 && rsp_day_out != 5'd0),
      "loaded result has a bad month or day")

endmodule

// File: verif/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

   localparam int SECS_IN_MIN  = 60;
   localparam int SECS_IN_HOUR = 3600;
   localparam int SECS_IN_DAY  = 86400;
   localparam int LATEST_HOUR  = 23;
   localparam int HOLD_CYCLES  = 800;
   localparam int TAIL_CYCLES  = 150;
   localparam int RUN_LIMIT    = 2000000;

   // one converted timestamp as the block presents it
   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [esc_pkg::SECS_W-1:0]    req_epoch_seconds = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [10:0]                   rsp_year_out;
   logic [3:0]                    rsp_month_out;
   logic [4:0]                    rsp_day_out;
   logic [4:0]                    rsp_hour_out;
   logic [5:0]                    rsp_minute_out;
   logic [5:0]                    rsp_second_out;
   logic                          csr_wr_en = 1'b0;
   logic [4:0]                    csr_wr_data = '0;

   calendar_type pending_dates[$];
   logic [4:0]  start_hour_now = 5'd8;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_start = 1'b0;
   int          hold_left = 0;
   int          cycles_run = 0;
   int          conversions_sent = 0;
   int          conversions_checked = 0;
   int          hour_settings = 1;
   int          mismatches = 0;

   epoch_seconds_to_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // gregorian leap rule
   function automatic bit leap_rule(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // month length, month counted from 0
   function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
      case (mon)
         1:           return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:     return 31;
      endcase
   endfunction

   // calendar date and time of a second count under a given start hour
   function automatic calendar_type civil_time_of(input logic [esc_pkg::SECS_W-1:0] secs,
                                                  input logic [4:0] zone_hour);
      longint unsigned total;
      longint unsigned days;
      int unsigned     hr0;
      int unsigned     yr;
      int unsigned     mon;
      int unsigned     span;
      calendar_type    c;
      hr0 = (zone_hour > LATEST_HOUR) ? LATEST_HOUR : zone_hour;
      total = 64'(secs) + 64'(hr0) * SECS_IN_HOUR;
      c.second = 6'(total % SECS_IN_MIN);
      c.minute = 6'((total / SECS_IN_MIN) % 60);
      c.hour = 5'((total / SECS_IN_HOUR) % 24);
      days = total / SECS_IN_DAY;
      // whole years first, then whole months
      yr = esc_pkg::EPOCH_YEAR;
      span = leap_rule(yr) ? 366 : 365;
      while (days >= span) begin
         days -= span;
         yr++;
         span = leap_rule(yr) ? 366 : 365;
      end
      mon = 0;
      while (mon < 11 && days >= days_in_month(mon, leap_rule(yr))) begin
         days -= days_in_month(mon, leap_rule(yr));
         mon++;
      end
      c.year = 11'(yr);
      c.month = 4'(mon + 1);
      c.day = 5'(days + 1);
      return c;
   endfunction

   // receiver: random stalls, or a long hold-off once asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // result checking against the oldest outstanding conversion
   always @(posedge clock) begin : check_results
      calendar_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                     $time, rsp_year_out, rsp_month_out, rsp_day_out,
                     rsp_hour_out, rsp_minute_out, rsp_second_out);
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            check_field("year_out", 32'(want.year), 32'(rsp_year_out));
            check_field("month_out", 32'(want.month), 32'(rsp_month_out));
            check_field("day_out", 32'(want.day), 32'(rsp_day_out));
            check_field("hour_out", 32'(want.hour), 32'(rsp_hour_out));
            check_field("minute_out", 32'(want.minute), 32'(rsp_minute_out));
            check_field("second_out", 32'(want.second), 32'(rsp_second_out));
            conversions_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == RUN_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycles_run, pending_dates.size());
         $display("epoch_seconds_to_calendar: mismatch");
         $finish;
      end
   end

   // offer one transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [esc_pkg::SECS_W-1:0] secs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back(civil_time_of(secs, start_hour_now));
      conversions_sent++;
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // start hour write, only while the block is idle
   task automatic set_start_hour(input logic [4:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      start_hour_now = value;
      hour_settings++;
   endtask

   // mix of full-range counts, early years and instants around midnight
   function automatic logic [esc_pkg::SECS_W-1:0] pick_seconds();
      longint unsigned t;
      case ($urandom_range(0, 3))
         0, 1: t = 64'($urandom);
         2:    t = 64'($urandom_range(0, 3 * 366 * SECS_IN_DAY));
         default: begin
            t = 64'($urandom_range(1, 24854)) * SECS_IN_DAY;
            t = t + $urandom_range(0, 119) - 60;
         end
      endcase
      return esc_pkg::SECS_W'(t);
   endfunction

   // start hour as it comes out of reset
   task automatic test_reset_value();
      send_item('0);
      send_item('1);
      wait_all_results();
   endtask

   // year, leap day and month boundaries at start hour 0
   task automatic test_calendar_edges();
      set_start_hour(5'd0);
      send_item(31'd59);
      send_item(31'd5097599);
      send_item(31'd5097600);
      send_item(31'd31535999);
      send_item(31'd31536000);
      send_item(31'd68169600);
      send_item(31'd94694399);
      send_item(31'd951782399);
      send_item(31'd951782400);
      send_item(31'd951868799);
      send_item(31'd978307199);
      send_item(31'h55555555);
      send_item(31'h2AAAAAAA);
      send_item(31'd2145916799);
      wait_all_results();
   endtask

   // start hours at and beyond the last hour of the day
   task automatic test_start_hour_saturation();
      set_start_hour(5'd23);
      send_item(31'd978307199);
      send_item('1);
      wait_all_results();
      set_start_hour(5'd24);
      send_item(31'd978307199);
      send_item('1);
      wait_all_results();
      set_start_hour(5'd31);
      send_item(31'd86399);
      send_item('1);
      wait_all_results();
   endtask

   // random traffic in three start hour settings
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int chunk;
      int k;
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      for (chunk = 0; chunk < 3; chunk++) begin
         set_start_hour(5'($urandom_range(0, 31)));
         for (k = 0; k < count / 3; k++) send_item(pick_seconds());
         wait_all_results();
      end
   endtask

   // long receiver hold-off while transactions keep arriving
   task automatic test_output_backpressure();
      int k;
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      set_start_hour(5'd8);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (k = 0; k < 12; k++) send_item(pick_seconds());
      wait_all_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_calendar_edges();
      test_start_hour_saturation();
      test_random_traffic(0, 0, 480);
      test_random_traffic(63, 0, 480);
      test_random_traffic(0, 63, 480);
      test_random_traffic(22, 22, 480);
      test_output_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d of %0d conversions checked over %0d start hour settings and four idle mixes",
               conversions_checked, conversions_sent, hour_settings);
      $display("includes one %0d cycle output hold-off with the input stalled behind it",
               HOLD_CYCLES);
      if (mismatches == 0 && pending_dates.size() == 0) begin
         $display("epoch_seconds_to_calendar: match");
      end else begin
         $display("%0d field errors, %0d results never arrived", mismatches,
                  pending_dates.size());
         $display("epoch_seconds_to_calendar: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_tb.sv
